// ----- design/iee_pkg.sv -----
// Shared types, token codes and controller/datapath interface for the expression evaluator.
package iee_pkg;

  // Port field widths fixed by the stream format
  localparam int OP_WIDTH           = 3;
  localparam int OPERAND_WIDTH      = 64;
  localparam int DATA_WIDTH_DEFAULT = 64;

  // Token kinds carried in s_tuser
  localparam logic [OP_WIDTH-1:0] TOK_NUM = 3'd0;
  localparam logic [OP_WIDTH-1:0] TOK_ADD = 3'd1;
  localparam logic [OP_WIDTH-1:0] TOK_SUB = 3'd2;
  localparam logic [OP_WIDTH-1:0] TOK_MUL = 3'd3;
  localparam logic [OP_WIDTH-1:0] TOK_DIV = 3'd4;

  // Pending multiplicative operator
  typedef enum logic [1:0] {
    MUL_NONE   = 2'd0,
    MUL_TIMES  = 2'd1,
    MUL_DIVIDE = 2'd2
  } mul_op_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_MUL,
    S_DIV,
    S_MUL_WB,
    S_DIV_WB,
    S_FINISH
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;   // register the accepted token
    logic apply;     // act on the token, start an iteration where needed
    logic mul_step;  // one shift-add step
    logic div_step;  // one restoring-division step
    logic mul_wb;    // write product back to the term
    logic div_wb;    // write signed quotient back to the term
    logic emit;      // load the result register and clear the expression
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic need_mul;   // token is a number with multiply pending
    logic need_div;   // token is a number with divide pending and non-zero divisor
    logic tok_last;   // token closes the expression
    logic iter_last;  // final iteration step this cycle
    logic out_free;   // result register can take a new result
  } sts_t;

endpackage

// ----- design/iee_ctrl.sv -----
// Controller state machine: sequences token capture, iteration and result hand-off.
module iee_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  iee_pkg::sts_t sts,
  output iee_pkg::cmd_t cmd
);
  import iee_pkg::*;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_DECODE;
      end
      S_DECODE: begin
        if (sts.need_mul)      state_next = S_MUL;
        else if (sts.need_div) state_next = S_DIV;
        else if (sts.tok_last) state_next = S_FINISH;
        else                   state_next = S_IDLE;
      end
      S_MUL: begin
        if (sts.iter_last) state_next = S_MUL_WB;
      end
      S_DIV: begin
        if (sts.iter_last) state_next = S_DIV_WB;
      end
      S_MUL_WB, S_DIV_WB: begin
        state_next = sts.tok_last ? S_FINISH : S_IDLE;
      end
      S_FINISH: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready    = 1'b1;
        cmd.capture = s_tvalid;
      end
      S_DECODE: cmd.apply    = 1'b1;
      S_MUL:    cmd.mul_step = 1'b1;
      S_DIV:    cmd.div_step = 1'b1;
      S_MUL_WB: cmd.mul_wb   = 1'b1;
      S_DIV_WB: cmd.div_wb   = 1'b1;
      S_FINISH: cmd.emit     = sts.out_free;
      default: ;
    endcase
  end

  // At most one datapath action per cycle
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.capture, cmd.apply, cmd.mul_step, cmd.div_step,
              cmd.mul_wb, cmd.div_wb, cmd.emit}))
    else $error("controller issued more than one command");

  // A pending multiply on a number always starts the multiplier
  a_mul_start: assert property (@(posedge clk) disable iff (rst)
    (state == S_DECODE && sts.need_mul) |=> state == S_MUL)
    else $error("multiply not started");

  // Iteration keeps going until its final step
  a_iter_hold: assert property (@(posedge clk) disable iff (rst)
    ((state == S_MUL || state == S_DIV) && !sts.iter_last) |=> $stable(state))
    else $error("iteration left early");

endmodule

// ----- design/iee_datapath.sv -----
// Datapath: expression state, shared shift-add multiplier / restoring divider, result register.
module iee_datapath #(
  parameter int DATA_WIDTH = iee_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [iee_pkg::OP_WIDTH-1:0]       s_tuser,
  input  logic [iee_pkg::OPERAND_WIDTH-1:0]  s_tdata,
  input  logic                               s_tlast,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [iee_pkg::OPERAND_WIDTH-1:0]  m_tdata,
  output logic                               m_tuser,
  input  iee_pkg::cmd_t                      cmd,
  output iee_pkg::sts_t                      sts
);
  import iee_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int CW = $clog2(W);

  // Captured token
  logic [OP_WIDTH-1:0] tok_op;
  logic [W-1:0]        tok_val;
  logic                tok_last;

  // Expression state
  logic [W-1:0] running_sum;
  logic [W-1:0] current_term;
  logic         add_minus;
  mul_op_t      mul_op;
  logic         error_seen;

  // Iteration registers: acc is product or remainder, opa multiplicand or
  // dividend/quotient, opb multiplier or divisor
  logic [W:0]    acc;
  logic [W-1:0]  opa;
  logic [W-1:0]  opb;
  logic          neg_q;
  logic [CW-1:0] count;

  logic [W-1:0] close_sum;
  logic [W-1:0] term_mag;
  logic [W-1:0] val_mag;
  logic [W:0]   rem_shift;
  logic         rem_ge;
  logic [W:0]   rem_sub;
  logic         is_num;
  logic         val_zero;
  logic signed [W-1:0] result_w;

  // Combinational helpers
  assign close_sum = add_minus ? running_sum - current_term : running_sum + current_term;
  assign term_mag  = current_term[W-1] ? -current_term : current_term;
  assign val_mag   = tok_val[W-1] ? -tok_val : tok_val;
  assign rem_shift = {acc[W-1:0], opa[W-1]};
  assign rem_sub   = rem_shift - {1'b0, opb};
  assign rem_ge    = rem_shift >= {1'b0, opb};
  assign is_num    = (tok_op == TOK_NUM);
  assign val_zero  = (tok_val == '0);
  assign result_w  = close_sum;

  // Status to controller
  always_comb begin
    sts           = '0;
    sts.need_mul  = is_num && (mul_op == MUL_TIMES);
    sts.need_div  = is_num && (mul_op == MUL_DIVIDE) && !val_zero;
    sts.tok_last  = tok_last;
    sts.iter_last = (count == CW'(W - 1));
    sts.out_free  = !m_tvalid || m_tready;
  end

  // Capture the accepted token
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      tok_op   <= s_tuser;
      tok_val  <= s_tdata[W-1:0];
      tok_last <= s_tlast;
    end
  end

  // Expression state update
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum  <= '0;
      current_term <= '0;
      add_minus    <= 1'b0;
      mul_op       <= MUL_NONE;
      error_seen   <= 1'b0;
    end else if (cmd.emit) begin
      running_sum  <= '0;
      current_term <= '0;
      add_minus    <= 1'b0;
      mul_op       <= MUL_NONE;
      error_seen   <= 1'b0;
    end else if (cmd.apply) begin
      case (tok_op)
        TOK_NUM: begin
          if (mul_op == MUL_NONE) begin
            current_term <= tok_val;
            mul_op       <= MUL_NONE;
          end else if (mul_op == MUL_DIVIDE && val_zero) begin
            // Zero divisor: drop the term and flag it
            current_term <= '0;
            error_seen   <= 1'b1;
            mul_op       <= MUL_NONE;
          end
        end
        TOK_ADD, TOK_SUB: begin
          running_sum  <= close_sum;
          current_term <= '0;
          add_minus    <= (tok_op == TOK_SUB);
          mul_op       <= MUL_NONE;
        end
        TOK_MUL: mul_op <= MUL_TIMES;
        TOK_DIV: mul_op <= MUL_DIVIDE;
        default: ;
      endcase
    end else if (cmd.mul_wb) begin
      current_term <= acc[W-1:0];
      mul_op       <= MUL_NONE;
    end else if (cmd.div_wb) begin
      current_term <= neg_q ? -opa : opa;
      mul_op       <= MUL_NONE;
    end
  end

  // Shared iteration unit: one bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      acc   <= '0;
      count <= '0;
      neg_q <= current_term[W-1] ^ tok_val[W-1];
      if (mul_op == MUL_DIVIDE) begin
        opa <= term_mag;
        opb <= val_mag;
      end else begin
        opa <= current_term;
        opb <= tok_val;
      end
    end else if (cmd.mul_step) begin
      if (opb[0]) acc <= {1'b0, acc[W-1:0] + opa};
      opa   <= {opa[W-2:0], 1'b0};
      opb   <= {1'b0, opb[W-1:1]};
      count <= count + 1'b1;
    end else if (cmd.div_step) begin
      acc   <= rem_ge ? rem_sub : rem_shift;
      opa   <= {opa[W-2:0], rem_ge};
      count <= count + 1'b1;
    end
  end

  // Result register, sign-extended to the port width
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= OPERAND_WIDTH'(result_w);
      m_tuser <= error_seen;
    end
  end

  // A result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!m_tvalid || m_tready))
    else $error("result register overwritten");

  // Expression state is clear after a result
  a_cleared: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> (running_sum == '0 && current_term == '0 && !error_seen
                  && mul_op == MUL_NONE))
    else $error("expression state not cleared");

  // Write-back follows the final iteration step, with the step count run out
  a_wb_count: assert property (@(posedge clk) disable iff (rst)
    (cmd.mul_wb || cmd.div_wb) |-> $past(cmd.mul_step || cmd.div_step)
                                   && count == CW'(W))
    else $error("write-back without completed iteration");

endmodule

// ----- design/infix_expression_evaluator_unit.sv -----
// Top level of the streaming infix expression evaluator.
//
//  Channel  Dir  Signals                     Contents
//  s_*      in   tvalid tready tdata tuser   token: tdata operand, tuser kind, tlast end
//           tlast
//  m_*      out  tvalid tready tdata tuser   result: tdata value, tuser divide-by-zero
//
//  Number or operator token: applied in the DECODE state, then ready returns.
//  Number after * or /: unless the divisor is zero, the bit-serial shift-add
//  multiplier / restoring divider that both share one iteration unit runs first.
//  Closing token: the FINISH state loads the result register; a further token
//  is taken while that result waits, but the next result waits on m_tready.
//  Reset (rst, synchronous) clears the expression state and the result valid flag.
module infix_expression_evaluator_unit #(
  parameter int DATA_WIDTH = iee_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [iee_pkg::OPERAND_WIDTH-1:0] s_tdata,  // [63:0] operand_value
  input  logic [iee_pkg::OP_WIDTH-1:0]      s_tuser,  // [2:0] op
  input  logic                              s_tlast,  // end_of_expression
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [iee_pkg::OPERAND_WIDTH-1:0] m_tdata,  // [63:0] expression_value
  output logic                              m_tuser   // [0] divide_by_zero
);
  import iee_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  iee_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Arithmetic and state
  iee_datapath #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

// ----- verif/tb_infix_expression_evaluator_unit.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the streaming infix expression evaluator: predicted results vs DUT.
module tb_infix_expression_evaluator_unit;
  import iee_pkg::*;

  localparam int ITEM_TARGET  = 1150;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = DATA_WIDTH_DEFAULT + 16;
  localparam int IDLE_PCT     = 7;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AFTER   = 40;

  // Token kinds that the block leaves alone
  localparam logic [OP_WIDTH-1:0] TOK_UNDEF_LO  = 3'd5;
  localparam logic [OP_WIDTH-1:0] TOK_UNDEF_MID = 3'd6;
  localparam logic [OP_WIDTH-1:0] TOK_UNDEF_HI  = 3'd7;

  localparam logic [63:0] VAL_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] VAL_MIN   = 64'h8000_0000_0000_0000;
  localparam logic [63:0] VAL_M_ONE = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic [OP_WIDTH-1:0] op;
    logic [63:0]         value;
    logic                last;
    logic                drain;  // hold this token back until all results are home
  } token_t;

  typedef struct {
    logic [63:0] value;
    logic        div_zero;
  } result_t;

  logic                     clk      = 1'b0;
  logic                     rst      = 1'b1;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [OPERAND_WIDTH-1:0] s_tdata  = '0;
  logic [OP_WIDTH-1:0]      s_tuser  = '0;
  logic                     s_tlast  = 1'b0;
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [OPERAND_WIDTH-1:0] m_tdata;
  logic                     m_tuser;

  token_t  token_q[$];
  result_t expected_results[$];
  token_t  on_bus;

  // Evaluator state as predicted
  logic [63:0] sum_acc     = '0;
  logic [63:0] term_acc    = '0;
  logic        sub_pending = 1'b0;
  mul_op_t     mul_pending = MUL_NONE;
  logic        div_err     = 1'b0;

  int errors       = 0;
  int item_count   = 0;
  int tok_accepted = 0;
  int results_seen = 0;
  int hold_left    = 0;
  bit hold_done    = 1'b0;
  int cycle_count  = 0;

  // No random idling on either side across this stretch of the run
  wire quiet = (tok_accepted >= 300) && (tok_accepted < 500);

  infix_expression_evaluator_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [63:0] closed_sum();
    return sub_pending ? sum_acc - term_acc : sum_acc + term_acc;
  endfunction

  // Advance the predicted state by one token; queue a result on the closing one
  task automatic fold_token(input token_t t);
    logic [63:0] mag_a;
    logic [63:0] mag_b;
    logic [63:0] quo;
    result_t     r;
    case (t.op)
      TOK_NUM: begin
        if (mul_pending == MUL_TIMES) begin
          term_acc = term_acc * t.value;
        end else if (mul_pending == MUL_DIVIDE) begin
          if (t.value == '0) begin
            term_acc = '0;
            div_err  = 1'b1;
          end else begin
            // truncate toward zero on magnitudes, then restore the sign
            mag_a    = term_acc[63] ? -term_acc : term_acc;
            mag_b    = t.value[63] ? -t.value : t.value;
            quo      = mag_a / mag_b;
            term_acc = (term_acc[63] != t.value[63]) ? -quo : quo;
          end
        end else begin
          term_acc = t.value;
        end
        mul_pending = MUL_NONE;
      end
      TOK_ADD, TOK_SUB: begin
        sum_acc     = closed_sum();
        term_acc    = '0;
        sub_pending = (t.op == TOK_SUB);
        mul_pending = MUL_NONE;
      end
      TOK_MUL: mul_pending = MUL_TIMES;
      TOK_DIV: mul_pending = MUL_DIVIDE;
      default: ;
    endcase
    if (t.last) begin
      r.value    = closed_sum();
      r.div_zero = div_err;
      expected_results.push_back(r);
      sum_acc     = '0;
      term_acc    = '0;
      sub_pending = 1'b0;
      mul_pending = MUL_NONE;
      div_err     = 1'b0;
    end
  endtask

  task automatic push_tok(input logic [OP_WIDTH-1:0] op, input logic [63:0] value,
                          input logic last, input logic drain = 1'b0);
    token_t t;
    t.op    = op;
    t.value = value;
    t.last  = last;
    t.drain = drain;
    token_q.push_back(t);
    if (op <= TOK_DIV) item_count++;
  endtask

  // Full-width noise and small numbers, with 32-bit values, zeros and extremes mixed in
  function automatic logic [63:0] rand_operand();
    int s;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        s = int'($urandom_range(0, 100)) - 50;
        return 64'(s);
      end
      3: return 64'(int'($urandom));
      4: return '0;
      5: begin
        case ($urandom_range(0, 3))
          0: return VAL_MAX;
          1: return VAL_MIN;
          2: return VAL_M_ONE;
          default: return 64'd1;
        endcase
      end
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [63:0] junk();
    return {$urandom, $urandom};
  endfunction

  // Well-formed expression: additive terms of multiplicative factors
  task automatic gen_expression(input logic drain);
    int n_terms;
    int n_factors;
    logic first;
    first   = drain;
    n_terms = $urandom_range(1, 6);
    for (int i = 0; i < n_terms; i++) begin
      if (i > 0) push_tok($urandom_range(0, 1) ? TOK_ADD : TOK_SUB, junk(), 1'b0);
      n_factors = $urandom_range(1, 3);
      for (int f = 0; f < n_factors; f++) begin
        if (f > 0) push_tok($urandom_range(0, 1) ? TOK_MUL : TOK_DIV, junk(), 1'b0);
        push_tok(TOK_NUM, rand_operand(), (i == n_terms - 1) && (f == n_factors - 1), first);
        first = 1'b0;
      end
    end
  endtask

  // Broken sequence: any token kind, stray closing marks, always closed at the end
  task automatic gen_noise();
    int n;
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++) begin
      push_tok(OP_WIDTH'($urandom_range(0, 7)), rand_operand(),
               (i == n - 1) || ($urandom_range(0, 4) == 0));
    end
  endtask

  // Driver: offer queued tokens, predict on each accepted transaction
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        fold_token(on_bus);
        tok_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (token_q.size() != 0 && !(token_q[0].drain && expected_results.size() != 0) &&
            (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
          on_bus = token_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= on_bus.value;
          s_tuser  <= on_bus.op;
          s_tlast  <= on_bus.last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transaction, throttle m_tready
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: value %h div_zero %b", $time, m_tdata, m_tuser);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (m_tdata !== want.value) begin
            $display("%0t: expression_value mismatch: expected %h actual %h",
                     $time, want.value, m_tdata);
            errors++;
          end
          if (m_tuser !== want.div_zero) begin
            $display("%0t: divide_by_zero mismatch: expected %b actual %b",
                     $time, want.div_zero, m_tuser);
            errors++;
          end
        end
      end
      // hold off once for a long stretch so the block backs up its input
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        m_tready <= 1'b0;
      end else begin
        m_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("infix_expression_evaluator_unit regression: fail");
      $finish;
    end
  end

  initial begin
    int n_expr;
    // wrap past the largest value, number replacing number
    push_tok(TOK_NUM, 64'd5, 1'b0);
    push_tok(TOK_NUM, VAL_MAX, 1'b0);
    push_tok(TOK_ADD, junk(), 1'b0);
    push_tok(TOK_NUM, 64'd1, 1'b1);
    // most negative value divided by minus one
    push_tok(TOK_NUM, VAL_MIN, 1'b0);
    push_tok(TOK_DIV, junk(), 1'b0);
    push_tok(TOK_NUM, VAL_M_ONE, 1'b1);
    // zero divisor, then a further term
    push_tok(TOK_NUM, 64'd7, 1'b0);
    push_tok(TOK_DIV, junk(), 1'b0);
    push_tok(TOK_NUM, '0, 1'b0);
    push_tok(TOK_SUB, junk(), 1'b0);
    push_tok(TOK_NUM, 64'd3, 1'b1);
    // later multiplicative op wins, additive drops a pending one, dangling divide
    push_tok(TOK_NUM, -64'sd7, 1'b0);
    push_tok(TOK_MUL, junk(), 1'b0);
    push_tok(TOK_DIV, junk(), 1'b0);
    push_tok(TOK_NUM, 64'd2, 1'b0);
    push_tok(TOK_MUL, junk(), 1'b0);
    push_tok(TOK_ADD, junk(), 1'b0);
    push_tok(TOK_NUM, 64'd1, 1'b0);
    push_tok(TOK_DIV, junk(), 1'b1);
    // undefined kinds, stray additive ops, undefined kind closing the expression
    push_tok(TOK_NUM, 64'd4, 1'b0);
    push_tok(TOK_UNDEF_LO, junk(), 1'b0);
    push_tok(TOK_ADD, junk(), 1'b0);
    push_tok(TOK_UNDEF_MID, junk(), 1'b0);
    push_tok(TOK_SUB, junk(), 1'b0);
    push_tok(TOK_UNDEF_HI, junk(), 1'b1);

    // random part, mostly well formed, with a few drained pauses
    n_expr = 0;
    while (item_count < ITEM_TARGET) begin
      if ($urandom_range(0, 99) < 15) gen_noise();
      else gen_expression((n_expr == 0) || (n_expr % 45 == 30));
      n_expr++;
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (token_q.size() != 0 || s_tvalid || expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("infix_expression_evaluator_unit regression: pass");
    end else begin
      $display("infix_expression_evaluator_unit regression: fail");
    end
    $finish;
  end

endmodule
